FILE: rtl/spi_pkg.sv
// Shared widths, codes and request/result types for the segment pair intersection unit.
package spi_pkg;

  localparam int CW   = 32;           // coordinate width
  localparam int DXW  = CW + 1;       // coordinate difference
  localparam int PRW  = 2 * DXW;      // product of two differences
  localparam int DETW = 2 * CW + 2;   // determinant, numerator, orientation value
  localparam int NUMU = 2 * CW + 1;   // numerator magnitude on a proper crossing
  localparam int PSW  = 3 * CW + 4;   // signed dividend
  localparam int NW   = 3 * CW + 3;   // dividend magnitude
  localparam int DW   = 2 * CW + 2;   // divisor (twice the determinant)
  localparam int QB   = CW + 2;       // quotient bits, one per divider stage
  localparam int QW   = QB + 1;       // signed quotient
  localparam int SUMW = QW + 1;       // quotient plus start coordinate
  localparam int LATENCY = QB + 11;   // accept edge to result edge

  localparam logic [1:0] TURN_COLL = 2'd0;
  localparam logic [1:0] TURN_CW   = 2'd1;
  localparam logic [1:0] TURN_CCW  = 2'd2;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] a_r1;
    logic signed [CW-1:0] a_z1;
    logic signed [CW-1:0] a_r2;
    logic signed [CW-1:0] a_z2;
    logic signed [CW-1:0] b_r1;
    logic signed [CW-1:0] b_z1;
    logic signed [CW-1:0] b_r2;
    logic signed [CW-1:0] b_z2;
  } seg_pair_t;

  typedef struct packed {
    logic                 hit;
    logic                 collinear;
    logic signed [CW-1:0] cross_r;
    logic signed [CW-1:0] cross_z;
    logic                 clipped;
  } cross_t;

endpackage

FILE: rtl/spi_div.sv
// Pipelined restoring divider giving a floored signed quotient, one bit per stage.
module spi_div (
  input  logic                            clk,
  input  logic [spi_pkg::NW-1:0]          num,
  input  logic [spi_pkg::DW-1:0]          den,
  input  logic                            neg,
  output logic signed [spi_pkg::QW-1:0]   quo
);

  localparam int QB = spi_pkg::QB;
  localparam int DW = spi_pkg::DW;
  localparam int NW = spi_pkg::NW;
  localparam int QW = spi_pkg::QW;

  logic [DW-1:0] rem_q  [QB];
  logic [QB-1:0] low_q  [QB];
  logic [QB-1:0] quo_q  [QB];
  logic [DW-1:0] den_q  [QB];
  logic          neg_q  [QB];

  logic [DW-1:0] rem_in [QB];
  logic [QB-1:0] low_in [QB];
  logic [QB-1:0] quo_in [QB];
  logic [DW-1:0] den_in [QB];
  logic          neg_in [QB];

  logic [DW:0]   trial  [QB];
  logic [DW:0]   diff   [QB];
  logic          ge     [QB];

  logic                 remnz;
  logic signed [QW-1:0] qs;

  always_comb begin
    // The top part of the dividend is already below the divisor on a proper crossing.
    rem_in[0] = DW'(num[NW-1:QB]);
    low_in[0] = num[QB-1:0];
    quo_in[0] = '0;
    den_in[0] = den;
    neg_in[0] = neg;
    for (int i = 1; i < QB; i++) begin
      rem_in[i] = rem_q[i-1];
      low_in[i] = low_q[i-1];
      quo_in[i] = quo_q[i-1];
      den_in[i] = den_q[i-1];
      neg_in[i] = neg_q[i-1];
    end
    for (int i = 0; i < QB; i++) begin
      trial[i] = {rem_in[i], low_in[i][QB-1]};
      diff[i]  = trial[i] - {1'b0, den_in[i]};
      ge[i]    = trial[i] >= {1'b0, den_in[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QB; i++) begin
      rem_q[i] <= ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
      low_q[i] <= low_in[i] << 1;
      quo_q[i] <= {quo_in[i][QB-2:0], ge[i]};
      den_q[i] <= den_in[i];
      neg_q[i] <= neg_in[i];
    end
  end

  assign remnz = rem_q[QB-1] != '0;
  assign qs    = {1'b0, quo_q[QB-1]};

  // A negative dividend floors toward minus infinity when a remainder is left.
  always_ff @(posedge clk) begin
    if (neg_q[QB-1]) begin
      quo <= -qs - QW'(remnz);
    end else begin
      quo <= qs;
    end
  end

endmodule

FILE: rtl/segment_pair_intersection_unit.sv
// Top level: segment pair overlap, orientation test and pipelined crossing point solve.
//
//  channel   ports                 handshake
//  request   start, busy, req      taken at a clock edge with start high and busy low
//  result    done, res             shown for one cycle, taken at the edge that ends it
//
// One request enters per cycle; every request gives one result.
// The divider resolves one quotient bit per stage; around it lie eleven stages
// of differences, products, sums and saturation.
// busy is high only during reset; reset drops every request in flight.
// The receiver cannot stall, so the pipeline never holds.
module segment_pair_intersection_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  spi_pkg::seg_pair_t    req,
  output logic                  done,
  output spi_pkg::cross_t       res
);

  localparam int CW   = spi_pkg::CW;
  localparam int DXW  = spi_pkg::DXW;
  localparam int PRW  = spi_pkg::PRW;
  localparam int DETW = spi_pkg::DETW;
  localparam int PSW  = spi_pkg::PSW;
  localparam int NW   = spi_pkg::NW;
  localparam int DW   = spi_pkg::DW;
  localparam int QB   = spi_pkg::QB;
  localparam int QW   = spi_pkg::QW;
  localparam int SUMW = spi_pkg::SUMW;
  localparam int SIDE = QB + 1;

  typedef struct packed {
    logic                 hit;
    logic                 coll;
    logic signed [CW-1:0] base_r;
    logic signed [CW-1:0] base_z;
  } side_t;

  function automatic logic signed [DXW-1:0] sub_x(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    sub_x = DXW'(a) - DXW'(b);
  endfunction

  function automatic logic [1:0] turn_code(input logic signed [DETW-1:0] x);
    if (x == '0) begin
      turn_code = spi_pkg::TURN_COLL;
    end else if (x[DETW-1]) begin
      turn_code = spi_pkg::TURN_CCW;
    end else begin
      turn_code = spi_pkg::TURN_CW;
    end
  endfunction

  function automatic logic on_span(input logic signed [CW-1:0] p,
                                   input logic signed [CW-1:0] q,
                                   input logic signed [CW-1:0] r);
    on_span = (q <= p || q <= r) && (q >= p || q >= r);
  endfunction

  assign busy = rst;

  // Stage 1: request register.
  logic               v1;
  spi_pkg::seg_pair_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    s1 <= req;
  end

  // Stage 2: differences and all the box comparisons.
  logic v2;
  logic signed [DXW-1:0] dar, daz, dbr, dbz, wr, wz;
  logic signed [DXW-1:0] e1r, e1z, e2r, e2z, f1r, f1z, gr, gz;
  logic ovl2, in1_2, in2_2, in3_2, in4_2;
  logic signed [CW-1:0] br2_base_r, br2_base_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dar <= sub_x(s1.a_r2, s1.a_r1);
    daz <= sub_x(s1.a_z2, s1.a_z1);
    dbr <= sub_x(s1.b_r2, s1.b_r1);
    dbz <= sub_x(s1.b_z2, s1.b_z1);
    wr  <= sub_x(s1.b_r1, s1.a_r1);
    wz  <= sub_x(s1.b_z1, s1.a_z1);
    e1r <= sub_x(s1.b_r1, s1.a_r2);
    e1z <= sub_x(s1.b_z1, s1.a_z2);
    e2r <= sub_x(s1.b_r2, s1.a_r2);
    e2z <= sub_x(s1.b_z2, s1.a_z2);
    f1r <= sub_x(s1.a_r1, s1.b_r2);
    f1z <= sub_x(s1.a_z1, s1.b_z2);
    gr  <= sub_x(s1.a_r2, s1.b_r2);
    gz  <= sub_x(s1.a_z2, s1.b_z2);
    ovl2 <= (s1.a_r1 >= s1.b_r1 || s1.a_r1 >= s1.b_r2 ||
             s1.a_r2 >= s1.b_r1 || s1.a_r2 >= s1.b_r2) &&
            (s1.a_r1 <= s1.b_r1 || s1.a_r1 <= s1.b_r2 ||
             s1.a_r2 <= s1.b_r1 || s1.a_r2 <= s1.b_r2) &&
            (s1.a_z1 >= s1.b_z1 || s1.a_z1 >= s1.b_z2 ||
             s1.a_z2 >= s1.b_z1 || s1.a_z2 >= s1.b_z2) &&
            (s1.a_z1 <= s1.b_z1 || s1.a_z1 <= s1.b_z2 ||
             s1.a_z2 <= s1.b_z1 || s1.a_z2 <= s1.b_z2);
    in1_2 <= on_span(s1.a_r1, s1.b_r1, s1.a_r2) && on_span(s1.a_z1, s1.b_z1, s1.a_z2);
    in2_2 <= on_span(s1.a_r1, s1.b_r2, s1.a_r2) && on_span(s1.a_z1, s1.b_z2, s1.a_z2);
    in3_2 <= on_span(s1.b_r1, s1.a_r1, s1.b_r2) && on_span(s1.b_z1, s1.a_z1, s1.b_z2);
    in4_2 <= on_span(s1.b_r1, s1.a_r2, s1.b_r2) && on_span(s1.b_z1, s1.a_z2, s1.b_z2);
    br2_base_r <= s1.a_r1;
    br2_base_z <= s1.a_z1;
  end

  // Stage 3: the twelve cross products.
  logic v3;
  logic signed [PRW-1:0] t1a, t1b, t2a, t2b, t3a, t3b, t4a, t4b, dta, dtb, nma, nmb;
  logic signed [DXW-1:0] dar3, daz3;
  logic ovl3, in1_3, in2_3, in3_3, in4_3;
  logic signed [CW-1:0] base_r3, base_z3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    t1a <= daz * e1r;
    t1b <= dar * e1z;
    t2a <= daz * e2r;
    t2b <= dar * e2z;
    t3a <= dbz * f1r;
    t3b <= dbr * f1z;
    t4a <= dbz * gr;
    t4b <= dbr * gz;
    dta <= dar * dbz;
    dtb <= daz * dbr;
    nma <= wr * dbz;
    nmb <= wz * dbr;
    dar3 <= dar;
    daz3 <= daz;
    ovl3 <= ovl2;
    in1_3 <= in1_2;
    in2_3 <= in2_2;
    in3_3 <= in3_2;
    in4_3 <= in4_2;
    base_r3 <= br2_base_r;
    base_z3 <= br2_base_z;
  end

  // Stage 4: orientation codes, determinant and numerator.
  logic v4;
  logic [1:0] o1, o2, o3, o4;
  logic signed [DETW-1:0] det4, num4;
  logic signed [DXW-1:0] dar4, daz4;
  logic ovl4, in1_4, in2_4, in3_4, in4_4;
  logic signed [CW-1:0] base_r4, base_z4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    o1 <= turn_code(DETW'(t1a) - DETW'(t1b));
    o2 <= turn_code(DETW'(t2a) - DETW'(t2b));
    o3 <= turn_code(DETW'(t3a) - DETW'(t3b));
    o4 <= turn_code(DETW'(t4a) - DETW'(t4b));
    det4 <= DETW'(dta) - DETW'(dtb);
    num4 <= DETW'(nma) - DETW'(nmb);
    dar4 <= dar3;
    daz4 <= daz3;
    ovl4 <= ovl3;
    in1_4 <= in1_3;
    in2_4 <= in2_3;
    in3_4 <= in3_3;
    in4_4 <= in4_3;
    base_r4 <= base_r3;
    base_z4 <= base_z3;
  end

  // Stage 5: intersection decision and a non-negative determinant.
  logic v5, hit5, coll5;
  logic signed [DETW-1:0] det5, num5;
  logic signed [DXW-1:0] dar5, daz5;
  logic signed [CW-1:0] base_r5, base_z5;
  logic meet4;

  assign meet4 = (o1 != o2 && o3 != o4) ||
                 (o1 == spi_pkg::TURN_COLL && in1_4) ||
                 (o2 == spi_pkg::TURN_COLL && in2_4) ||
                 (o3 == spi_pkg::TURN_COLL && in3_4) ||
                 (o4 == spi_pkg::TURN_COLL && in4_4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    hit5  <= ovl4 && meet4;
    coll5 <= ovl4 && meet4 && det4 == '0;
    det5  <= det4[DETW-1] ? -det4 : det4;
    num5  <= det4[DETW-1] ? -num4 : num4;
    dar5  <= dar4;
    daz5  <= daz4;
    base_r5 <= base_r4;
    base_z5 <= base_z4;
  end

  // Stage 6: delta times numerator, cut into two partial products per axis.
  // On a proper crossing the numerator lies between zero and the determinant.
  localparam int PLW = DXW + CW + 2;
  localparam int PHW = DXW + CW + 1;
  logic v6, hit6, coll6;
  logic signed [PLW-1:0] plo_r, plo_z;
  logic signed [PHW-1:0] phi_r, phi_z;
  logic signed [DETW-1:0] det6;
  logic signed [CW-1:0] base_r6, base_z6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    plo_r <= dar5 * $signed({1'b0, num5[CW:0]});
    plo_z <= daz5 * $signed({1'b0, num5[CW:0]});
    phi_r <= dar5 * $signed({1'b0, num5[2*CW:CW+1]});
    phi_z <= daz5 * $signed({1'b0, num5[2*CW:CW+1]});
    det6  <= det5;
    hit6  <= hit5;
    coll6 <= coll5;
    base_r6 <= base_r5;
    base_z6 <= base_z5;
  end

  // Stage 7: dividend 2 * delta * num + det.
  logic v7, hit7, coll7;
  logic signed [PSW-1:0] p_r, p_z;
  logic signed [DETW-1:0] det7;
  logic signed [CW-1:0] base_r7, base_z7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    p_r <= (((PSW'(phi_r) <<< (CW + 1)) + PSW'(plo_r)) <<< 1) + PSW'(det6);
    p_z <= (((PSW'(phi_z) <<< (CW + 1)) + PSW'(plo_z)) <<< 1) + PSW'(det6);
    det7  <= det6;
    hit7  <= hit6;
    coll7 <= coll6;
    base_r7 <= base_r6;
    base_z7 <= base_z6;
  end

  // Stage 8: sign and magnitude for the divider.
  logic v8;
  logic [NW-1:0] mag_r, mag_z;
  logic neg_r, neg_z;
  logic [DW-1:0] den8;
  side_t side8;
  logic signed [PSW-1:0] ap_r, ap_z;

  assign ap_r = p_r[PSW-1] ? -p_r : p_r;
  assign ap_z = p_z[PSW-1] ? -p_z : p_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    mag_r <= ap_r[NW-1:0];
    mag_z <= ap_z[NW-1:0];
    neg_r <= p_r[PSW-1];
    neg_z <= p_z[PSW-1];
    den8  <= {det7[DW-2:0], 1'b0};
    side8 <= '{hit: hit7, coll: coll7, base_r: base_r7, base_z: base_z7};
  end

  logic signed [QW-1:0] q_r, q_z;

  spi_div u_div_r (.clk(clk), .num(mag_r), .den(den8), .neg(neg_r), .quo(q_r));
  spi_div u_div_z (.clk(clk), .num(mag_z), .den(den8), .neg(neg_z), .quo(q_z));

  // Side data and valid bits travel alongside the divider.
  side_t side_q [SIDE];
  logic  sv_q   [SIDE];

  always_ff @(posedge clk) begin
    side_q[0] <= side8;
    for (int i = 1; i < SIDE; i++) begin
      side_q[i] <= side_q[i-1];
    end
    if (rst) begin
      for (int i = 0; i < SIDE; i++) begin
        sv_q[i] <= 1'b0;
      end
    end else begin
      sv_q[0] <= v8;
      for (int i = 1; i < SIDE; i++) begin
        sv_q[i] <= sv_q[i-1];
      end
    end
  end

  // Add the start coordinate.
  logic vf, hitf, collf;
  logic signed [SUMW-1:0] sum_r, sum_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else begin
      vf <= sv_q[SIDE-1];
    end
    sum_r <= SUMW'(q_r) + SUMW'(side_q[SIDE-1].base_r);
    sum_z <= SUMW'(q_z) + SUMW'(side_q[SIDE-1].base_z);
    hitf  <= side_q[SIDE-1].hit;
    collf <= side_q[SIDE-1].coll;
  end

  // Saturate and present the result.
  logic hi_r, lo_r, hi_z, lo_z, point;

  assign hi_r  = sum_r > SUMW'(spi_pkg::CMAX);
  assign lo_r  = sum_r < SUMW'(spi_pkg::CMIN);
  assign hi_z  = sum_z > SUMW'(spi_pkg::CMAX);
  assign lo_z  = sum_z < SUMW'(spi_pkg::CMIN);
  assign point = hitf && !collf;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vf;
    end
    res.hit       <= hitf;
    res.collinear <= collf;
    res.clipped   <= point && (hi_r || lo_r || hi_z || lo_z);
    if (!point) begin
      res.cross_r <= '0;
      res.cross_z <= '0;
    end else begin
      res.cross_r <= hi_r ? spi_pkg::CMAX : (lo_r ? spi_pkg::CMIN : sum_r[CW-1:0]);
      res.cross_z <= hi_z ? spi_pkg::CMAX : (lo_z ? spi_pkg::CMIN : sum_z[CW-1:0]);
    end
  end

endmodule

FILE: rtl/spi_chk.sv
// Port checker for the segment pair intersection unit, with its bind.
module spi_chk (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input spi_pkg::cross_t res
);

  // Every result answers a request taken a fixed number of cycles earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, spi_pkg::LATENCY))
    else $error("result without a matching request");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !res.hit |-> res.cross_r == '0 && res.cross_z == '0 &&
                         !res.collinear && !res.clipped)
    else $error("miss carries a point or a flag");

  a_coll: assert property (@(posedge clk) disable iff (rst)
    done && res.collinear |-> res.hit && res.cross_r == '0 && res.cross_z == '0 &&
                              !res.clipped)
    else $error("collinear result is malformed");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    done && res.clipped |-> res.hit && !res.collinear)
    else $error("clipped flag without a crossing point");

endmodule

bind segment_pair_intersection_unit spi_chk u_spi_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);
